>>> hw/rtl/bls_pkg.sv
package bls_pkg;

	// Field widths fixed by the word layout
	localparam int LEVEL_W   = 16;
	localparam int COORD_W   = 20;
	localparam int LOAD_W    = 9;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int IN_DATA_W = 80;
	localparam int IN_USER_W = 2;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 2;

	// Defaults handed to the top level
	localparam int MAX_SIDE_DEF  = 512;
	localparam int FRAC_BITS_DEF = 8;
	localparam int CFG_RESET     = 512;

	// Number of parity banks (row parity, column parity)
	localparam int NUM_BANKS = 4;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	// One stored pixel: invalid mark above a signed Q8.8 level
	typedef struct packed {
		logic                      inv;
		logic signed [LEVEL_W-1:0] lvl;
	} pix_t;

	localparam int PIX_W = $bits(pix_t);

	// Bad means invalid or not above zero
	function automatic logic is_bad(input pix_t p);
		return p.inv || (p.lvl <= 0);
	endfunction

endpackage

>>> hw/rtl/bls_ram.sv
module bls_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/bilinear_sampler_bad_skip.sv
// Channel | Dir | Bits                      | Word
// s_*     | in  | tdata 80, tuser 2         | pixel load (op 0) or sample request (op 1)
// m_*     | out | tdata 16, tuser 2         | one interpolated sample per request
// cfg_*   | in  | we, index 1, wdata 10     | image_width (0), image_height (1)
//
// One word is taken every cycle while s_tready is high; loads and samples mix freely.
// A sample passes the input register, bank read, vertical multiply, column select,
// horizontal multiply and output register on its way out.
// The image sits in four banks split on row and column parity, so the four
// corners are read in the same cycle. Reset clears control state only; pixels are
// undefined until loaded. One result may wait at the output while the pipe runs
// on; s_tready drops only when a second finished result is parked in the skid.
module bilinear_sampler_bad_skip #(
	parameter int MAX_SIDE  = bls_pkg::MAX_SIDE_DEF,
	parameter int FRAC_BITS = bls_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// load_col[8:0], load_row[17:9], pixel_level[33:18], sample_x[53:34],
	// sample_y[73:54], skip_bad[74], zero[79:75]
	input  logic [bls_pkg::IN_DATA_W-1:0]     s_tdata,
	// op[0], pixel_invalid[1]
	input  logic [bls_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// sample_level[15:0]
	output logic [bls_pkg::OUT_DATA_W-1:0]    m_tdata,
	// sample_invalid[0], sample_bad[1]
	output logic [bls_pkg::OUT_USER_W-1:0]    m_tuser,
	input  logic                              cfg_we,
	input  logic [bls_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bls_pkg::CFG_W-1:0]         cfg_wdata
);
	import bls_pkg::*;

	localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int HW    = (IW > 1) ? IW - 1 : 1;
	localparam int AW    = 2 * HW;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = COORD_W - FRAC_BITS + 1;
	localparam int PW    = LEVEL_W + FRAC_BITS + 2;
	localparam int RST_LIM = ((CFG_RESET > MAX_SIDE) ? MAX_SIDE : CFG_RESET) - 1;

	// Highest index for a register value: zero acts as one, large values clip
	function automatic logic [IW-1:0] side_lim(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return '0;
		end else if (32'(v) > MAX_SIDE) begin
			return IW'(MAX_SIDE - 1);
		end else begin
			return IW'(v - CFG_W'(1));
		end
	endfunction

	function automatic logic [IW-1:0] clamp_idx(input logic signed [CW-1:0] v,
			input logic [IW-1:0] lim);
		if (v < 0) begin
			return '0;
		end else if (v > $signed({1'b0, lim})) begin
			return lim;
		end else begin
			return IW'(v);
		end
	endfunction

	function automatic logic [AW-1:0] bank_addr(input logic [IW-1:0] row,
			input logic [IW-1:0] col);
		return {HW'(row >> 1), HW'(col >> 1)};
	endfunction

	// Finish a blend: a + floor(prod / 2^F), invalid if either side is
	function automatic pix_t blend_fin(input pix_t a, input pix_t b,
			input logic signed [PW-1:0] prod);
		logic signed [PW-1:0] sum;
		pix_t r;
		sum = PW'(a.lvl) + (prod >>> FRAC_BITS);
		r.lvl = sum[LEVEL_W-1:0];
		r.inv = a.inv || b.inv;
		return r;
	endfunction

	function automatic pix_t pick(input pix_t a, input pix_t b,
			input logic signed [PW-1:0] prod, input logic skip);
		if (skip && is_bad(a)) begin
			return b;
		end else if (skip && is_bad(b)) begin
			return a;
		end else begin
			return blend_fin(a, b, prod);
		end
	endfunction

	logic adv;
	logic [IW-1:0] wlim_q, hlim_q;

	// Configuration: keep the clamp limits ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlim_q <= IW'(RST_LIM);
			hlim_q <= IW'(RST_LIM);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  wlim_q <= side_lim(cfg_wdata);
				REG_IMAGE_HEIGHT: hlim_q <= side_lim(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Unpack the input word
	logic [LOAD_W-1:0]         ld_col, ld_row;
	logic signed [COORD_W-1:0] sx, sy;
	logic                      is_sample;
	pix_t                      ld_pix;

	assign ld_col     = s_tdata[8:0];
	assign ld_row     = s_tdata[17:9];
	assign ld_pix.lvl = s_tdata[33:18];
	assign ld_pix.inv = s_tuser[1];
	assign sx         = s_tdata[53:34];
	assign sy         = s_tdata[73:54];
	assign is_sample  = (s_tuser[0] == OP_SAMPLE);

	// Corner indices, clamped to the image
	logic signed [CW-1:0] fx0, fx1, fy0, fy1;
	logic [IW-1:0]        c0, c1, r0, r1, lc, lr;
	logic                 ld_ok;

	assign fx0 = CW'(sx >>> FRAC_BITS);
	assign fy0 = CW'(sy >>> FRAC_BITS);
	assign fx1 = fx0 + CW'(1);
	assign fy1 = fy0 + CW'(1);
	assign c0  = clamp_idx(fx0, wlim_q);
	assign c1  = clamp_idx(fx1, wlim_q);
	assign r0  = clamp_idx(fy0, hlim_q);
	assign r1  = clamp_idx(fy1, hlim_q);
	assign lc  = IW'(ld_col);
	assign lr  = IW'(ld_row);
	assign ld_ok = (32'(ld_col) < MAX_SIDE) && (32'(ld_row) < MAX_SIDE);

	// Bank addresses and write strobes for the incoming word
	logic [AW-1:0] addr_s0 [NUM_BANKS];
	logic [NUM_BANKS-1:0] we_s0;

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_addr
		localparam logic PR = 1'((b >> 1) & 1);
		localparam logic PC = 1'(b & 1);
		logic [IW-1:0] row, col;
		assign row = (r0[0] == PR) ? r0 : r1;
		assign col = (c0[0] == PC) ? c0 : c1;
		assign addr_s0[b] = is_sample ? bank_addr(row, col) : bank_addr(lr, lc);
		assign we_s0[b]   = !is_sample && ld_ok && (lr[0] == PR) && (lc[0] == PC);
	end

	// Stage 1: registered word, drives the banks
	logic                 v1_q, smp_s1, skip_s1;
	logic [AW-1:0]        addr_s1 [NUM_BANKS];
	logic [NUM_BANKS-1:0] we_s1;
	pix_t                 wd_s1;
	logic [1:0]           tsel_s1, bsel_s1;
	logic                 c1p_s1;
	logic [FRAC_BITS-1:0] fx_s1, fy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (adv) begin
			v1_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			smp_s1  <= is_sample;
			skip_s1 <= s_tdata[74];
			addr_s1 <= addr_s0;
			we_s1   <= we_s0;
			wd_s1   <= ld_pix;
			tsel_s1 <= {r0[0], c0[0]};
			bsel_s1 <= {r1[0], c0[0]};
			c1p_s1  <= c1[0];
			fx_s1   <= sx[FRAC_BITS-1:0];
			fy_s1   <= sy[FRAC_BITS-1:0];
		end
	end

	pix_t bank_rd [NUM_BANKS];

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [PIX_W-1:0] rd;
		bls_ram #(
			.WIDTH(PIX_W),
			.DEPTH(DEPTH)
		) u_bank (
			.clk  (clk),
			.we   (we_s1[b] && v1_q && adv),
			.waddr(addr_s1[b]),
			.wdata(wd_s1),
			.re   (adv),
			.raddr(addr_s1[b]),
			.rdata(rd)
		);
		assign bank_rd[b] = pix_t'(rd);
	end

	// Stage 2: bank data arrives, route corners and multiply vertically
	logic                 v2_q, skip_s2, c1p_s2;
	logic [1:0]           tsel_s2, bsel_s2;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv) begin
			v2_q <= v1_q && smp_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s2 <= skip_s1;
			tsel_s2 <= tsel_s1;
			bsel_s2 <= bsel_s1;
			c1p_s2  <= c1p_s1;
			fx_s2   <= fx_s1;
			fy_s2   <= fy_s1;
		end
	end

	pix_t tl, tr, bl, br;
	logic signed [PW-1:0] prodl, prodr;

	assign tl = bank_rd[tsel_s2];
	assign bl = bank_rd[bsel_s2];
	assign tr = bank_rd[{tsel_s2[1], c1p_s2}];
	assign br = bank_rd[{bsel_s2[1], c1p_s2}];
	assign prodl = (PW'(bl.lvl) - PW'(tl.lvl)) * $signed({1'b0, fy_s2});
	assign prodr = (PW'(br.lvl) - PW'(tr.lvl)) * $signed({1'b0, fy_s2});

	// Stage 3: finish the columns
	logic                 v3_q, skip_s3;
	pix_t                 tl_s3, tr_s3, bl_s3, br_s3;
	logic signed [PW-1:0] prodl_s3, prodr_s3;
	logic [FRAC_BITS-1:0] fx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
		end else if (adv) begin
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s3  <= skip_s2;
			tl_s3    <= tl;
			tr_s3    <= tr;
			bl_s3    <= bl;
			br_s3    <= br;
			prodl_s3 <= prodl;
			prodr_s3 <= prodr;
			fx_s3    <= fx_s2;
		end
	end

	pix_t left, right;

	assign left  = pick(tl_s3, bl_s3, prodl_s3, skip_s3);
	assign right = pick(tr_s3, br_s3, prodr_s3, skip_s3);

	// Stage 4: multiply horizontally
	logic                 v4_q, skip_s4;
	pix_t                 left_s4, right_s4;
	logic [FRAC_BITS-1:0] fx_s4;
	logic signed [PW-1:0] prodh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_q <= 1'b0;
		end else if (adv) begin
			v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s4  <= skip_s3;
			left_s4  <= left;
			right_s4 <= right;
			fx_s4    <= fx_s3;
		end
	end

	assign prodh = (PW'(right_s4.lvl) - PW'(left_s4.lvl)) * $signed({1'b0, fx_s4});

	// Stage 5: final blend
	logic                 v5_q, skip_s5;
	pix_t                 left_s5, right_s5;
	logic signed [PW-1:0] prodh_s5;
	pix_t                 res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v5_q <= 1'b0;
		end else if (adv) begin
			v5_q <= v4_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			skip_s5  <= skip_s4;
			left_s5  <= left_s4;
			right_s5 <= right_s4;
			prodh_s5 <= prodh;
		end
	end

	assign res = pick(left_s5, right_s5, prodh_s5, skip_s5);

	// Output register with one skid entry behind it
	logic out_valid_q, skid_valid_q;
	pix_t out_q, skid_q;

	assign adv      = !skid_valid_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !m_tready) begin
			skid_valid_q <= skid_valid_q || (adv && v5_q);
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv && v5_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !m_tready) begin
			if (adv) begin
				skid_q <= res;
			end
		end else if (skid_valid_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_q.lvl;
	assign m_tuser[0] = out_q.inv;
	assign m_tuser[1] = is_bad(out_q);

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output word");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled while output is empty");

	a_invalid_is_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1])
		else $error("invalid sample not flagged bad");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && m_tready |=> !skid_valid_q && m_tvalid)
		else $error("skid entry not moved to output");
`endif

endmodule
